### rtl/wfr_pkg.sv
// shared types and constants of the wiegand frame receiver
// no dependencies; every file that uses it refers to it by scoped names
package wfr_pkg;

  // field widths fixed by the item formats
  localparam int OPCODE_W    = 2;
  localparam int MAXB_W      = 7;
  localparam int BIT_COUNT_W = 9;
  localparam int BYTE_W      = 8;
  localparam int TIMER_W     = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // most bytes a single read can return
  localparam int RESULT_CAP = 32;

  localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd4000;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_DATA0 = 2'd1,
    OP_DATA1 = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STREAM,
    S_EMPTY
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic tick;
    logic pulse;
    logic pulse_bit;
    logic rd_latch;
    logic rd_fetch;
    logic rd_adv;
    logic load_byte;
    logic load_empty;
    logic clear;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic complete;
    logic n_zero;
    logic out_free;
    logic last_idx;
    logic rd_cmpl;
  } dp_stat_t;

endpackage

### rtl/wfr_in_if.sv
// input channel: opcode and max_bytes with a valid/ready handshake
// uses wfr_pkg for field widths
interface wfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [wfr_pkg::OPCODE_W-1:0] opcode;
  logic [wfr_pkg::MAXB_W-1:0]   max_bytes;

  modport source (output valid, output opcode, output max_bytes, input ready);
  modport sink   (input valid, input opcode, input max_bytes, output ready);
endinterface

### rtl/wfr_out_if.sv
// result channel: bit count, frame byte and flags with a valid/ready handshake
// uses wfr_pkg for field widths
interface wfr_out_if;
  logic                            valid;
  logic                            ready;
  logic [wfr_pkg::BIT_COUNT_W-1:0] bit_count;
  logic [wfr_pkg::BYTE_W-1:0]      data_byte;
  logic                            byte_valid;
  logic                            last;

  modport source (output valid, output bit_count, output data_byte, output byte_valid,
                  output last, input ready);
  modport sink   (input valid, input bit_count, input data_byte, input byte_valid,
                  input last, output ready);
endinterface

### rtl/wfr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module wfr_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/wfr_ctrl.sv
// controller state machine: decodes accepted items and sequences reads
// depends on wfr_pkg
module wfr_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [wfr_pkg::OPCODE_W-1:0] in_opcode,
  output logic                         in_ready,
  input  wfr_pkg::dp_stat_t            stat,
  output wfr_pkg::ctrl_cmd_t           cmd
);

  wfr_pkg::state_t state_r, state_nxt;
  logic            accept;

  assign in_ready = (state_r == wfr_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wfr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wfr_pkg::S_IDLE: begin
        if (accept && wfr_pkg::opcode_t'(in_opcode) == wfr_pkg::OP_READ) begin
          if (stat.complete && !stat.n_zero) begin
            state_nxt = wfr_pkg::S_STREAM;
          end else begin
            state_nxt = wfr_pkg::S_EMPTY;
          end
        end
      end
      wfr_pkg::S_STREAM: begin
        if (stat.out_free && stat.last_idx) begin
          state_nxt = wfr_pkg::S_IDLE;
        end
      end
      wfr_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          state_nxt = wfr_pkg::S_IDLE;
        end
      end
      default: state_nxt = wfr_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      wfr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (wfr_pkg::opcode_t'(in_opcode))
            wfr_pkg::OP_TICK:  cmd.tick = 1'b1;
            wfr_pkg::OP_DATA0: cmd.pulse = 1'b1;
            wfr_pkg::OP_DATA1: begin
              cmd.pulse     = 1'b1;
              cmd.pulse_bit = 1'b1;
            end
            wfr_pkg::OP_READ: begin
              cmd.rd_latch = 1'b1;
              cmd.rd_fetch = stat.complete && !stat.n_zero;
            end
            default: cmd.tick = 1'b0;
          endcase
        end
      end
      wfr_pkg::S_STREAM: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          cmd.clear     = stat.last_idx;
          cmd.rd_adv    = !stat.last_idx;
        end
      end
      wfr_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          cmd.clear      = stat.rd_cmpl;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/wfr_dp.sv
// datapath: frame store, bit count, idle timer, read walker and result register
// depends on wfr_pkg and wfr_ram
module wfr_dp #(
  parameter int MAX_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wfr_pkg::ctrl_cmd_t              cmd,
  output wfr_pkg::dp_stat_t               stat,
  input  logic [wfr_pkg::MAXB_W-1:0]      max_bytes,
  input  logic [wfr_pkg::TIMER_W-1:0]     timeout,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [wfr_pkg::BIT_COUNT_W-1:0] out_bit_count,
  output logic [wfr_pkg::BYTE_W-1:0]      out_data_byte,
  output logic                            out_byte_valid,
  output logic                            out_last
);

  localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int BITS_W = $clog2(MAX_BYTES * 8 + 1);
  localparam int SLOT_W = BITS_W - 3;
  localparam int RD_CAP = (MAX_BYTES < wfr_pkg::RESULT_CAP) ? MAX_BYTES
                                                             : wfr_pkg::RESULT_CAP;
  localparam int CNT_W  = $clog2(RD_CAP + 1);
  localparam int CMP_W  = 8;

  logic [BITS_W-1:0]               bits_r, bits_nxt;
  logic [wfr_pkg::TIMER_W-1:0]     timer_r, timer_nxt;
  logic [wfr_pkg::BYTE_W-1:0]      cur_byte_r, cur_byte_nxt;
  logic [MAX_BYTES-1:0]            vld_r, vld_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt, idx_inc;
  logic [CNT_W-1:0]                n_r;
  logic [wfr_pkg::BIT_COUNT_W-1:0] rd_bits_r;
  logic                            rd_cmpl_r;
  logic                            vq_r;

  logic                            out_valid_r, out_valid_nxt;
  logic [wfr_pkg::BIT_COUNT_W-1:0] out_bits_r;
  logic [wfr_pkg::BYTE_W-1:0]      out_byte_r;
  logic                            out_bv_r;
  logic                            out_last_r;

  logic [SLOT_W-1:0]               slot;
  logic                            full;
  logic                            wr_en;
  logic [wfr_pkg::BYTE_W-1:0]      shift_base, new_byte;
  logic [ADDR_W-1:0]               waddr, raddr;
  logic                            re;
  logic [wfr_pkg::BYTE_W-1:0]      ram_q;
  logic [BITS_W+wfr_pkg::BIT_COUNT_W-1:0] bits_wide;
  logic [wfr_pkg::BIT_COUNT_W-1:0] bits9;
  logic [CMP_W-1:0]                ceil8, maxb8, n8, n_tmp;
  logic                            complete;
  logic                            out_free;

  // write side of the store
  assign slot       = bits_r[BITS_W-1:3];
  assign full       = (slot >= SLOT_W'(MAX_BYTES));
  assign wr_en      = cmd.pulse && !full;
  assign shift_base = (bits_r[2:0] == 3'd0) ? '0 : cur_byte_r;
  assign new_byte   = {shift_base[wfr_pkg::BYTE_W-2:0], cmd.pulse_bit};
  assign waddr      = slot[ADDR_W-1:0];

  // frame length and completion
  assign bits_wide = {{wfr_pkg::BIT_COUNT_W{1'b0}}, bits_r};
  assign bits9     = bits_wide[wfr_pkg::BIT_COUNT_W-1:0];
  assign complete  = (timer_r >= timeout) && (bits_r != '0);

  // byte count of a read: min(ceil(bits/8), max_bytes, cap)
  assign ceil8 = CMP_W'(slot) + CMP_W'(|bits_r[2:0]);
  assign maxb8 = CMP_W'(max_bytes);
  always_comb begin
    n_tmp = (ceil8 < maxb8) ? ceil8 : maxb8;
    n8    = (n_tmp < CMP_W'(RD_CAP)) ? n_tmp : CMP_W'(RD_CAP);
  end

  // read walker addressing
  assign idx_inc = idx_r + CNT_W'(1);
  assign re      = cmd.rd_fetch || cmd.rd_adv;
  assign raddr   = cmd.rd_fetch ? '0 : idx_inc[ADDR_W-1:0];

  assign out_free = !out_valid_r || out_ready;

  // status to the controller
  always_comb begin
    stat          = '0;
    stat.complete = complete;
    stat.n_zero   = (n8 == '0);
    stat.out_free = out_free;
    stat.last_idx = (idx_inc == n_r);
    stat.rd_cmpl  = rd_cmpl_r;
  end

  // frame state next values
  always_comb begin
    bits_nxt     = bits_r;
    timer_nxt    = timer_r;
    cur_byte_nxt = cur_byte_r;
    vld_nxt      = vld_r;
    idx_nxt      = idx_r;
    if (cmd.tick && timer_r != wfr_pkg::TIMER_MAX) begin
      timer_nxt = timer_r + 16'd1;
    end
    if (cmd.pulse) begin
      timer_nxt = '0;
    end
    if (wr_en) begin
      bits_nxt       = bits_r + BITS_W'(1);
      cur_byte_nxt   = new_byte;
      vld_nxt[waddr] = 1'b1;
    end
    if (cmd.clear) begin
      bits_nxt = '0;
      vld_nxt  = '0;
    end
    if (cmd.rd_fetch) begin
      idx_nxt = '0;
    end else if (cmd.rd_adv) begin
      idx_nxt = idx_inc;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r      <= '0;
      timer_r     <= wfr_pkg::TIMER_MAX;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bits_r      <= bits_nxt;
      timer_r     <= timer_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_byte_r <= cur_byte_nxt;
    idx_r      <= idx_nxt;
    if (cmd.rd_latch) begin
      n_r       <= CNT_W'(n8);
      rd_bits_r <= complete ? bits9 : '0;
      rd_cmpl_r <= complete;
    end
    if (re) begin
      vq_r <= vld_r[raddr];
    end
    if (cmd.load_byte) begin
      out_bits_r <= rd_bits_r;
      out_byte_r <= vq_r ? ram_q : '0;
      out_bv_r   <= 1'b1;
      out_last_r <= stat.last_idx;
    end else if (cmd.load_empty) begin
      out_bits_r <= rd_bits_r;
      out_byte_r <= '0;
      out_bv_r   <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_byte || cmd.load_empty) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // frame byte store
  wfr_ram #(
    .WIDTH (wfr_pkg::BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (new_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign out_valid      = out_valid_r;
  assign out_bit_count  = out_bits_r;
  assign out_data_byte  = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;

  // a finished read leaves an empty store
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (bits_r == '0 && vld_r == '0))
    else $error("store not empty after read");

  // results only enter a free result register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_byte || cmd.load_empty) |-> out_free)
    else $error("result register overwritten");

  // a pulse on a full store keeps the bit count
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pulse && full) |=> $stable(bits_r))
    else $error("bit counted on full store");

  // streaming starts only on a complete frame
  a_fetch_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_fetch |-> (complete && bits_r != '0))
    else $error("stream started on incomplete frame");

endmodule

### rtl/wiegand_frame_receiver_core.sv
// top level of the wiegand frame receiver: config register, controller, datapath
// depends on wfr_pkg, wfr_in_if, wfr_out_if, wfr_ctrl, wfr_dp
//
// Ticks and data pulses can follow back to back. A read holds the input until its
// last result has entered the result register: the read first issues address 0 to
// the frame store, then the store's registered read port delivers one byte per
// cycle into the result register while that register is free, so sink back
// pressure holds the read. A read that returns no byte gives one result with no
// byte. The next item is accepted as soon as the last result of a read has entered
// the result register. The store has one valid flag per byte, so reset and the
// clear after a read take effect at once with no sweep. timeout_ticks lies at byte
// address 0 of the config port.
module wiegand_frame_receiver_core #(
  parameter int MAX_BYTES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wfr_in_if.sink                           in_ch,
  wfr_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [wfr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wfr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  logic [wfr_pkg::TIMER_W-1:0] timeout_r, timeout_nxt;
  logic                        cfg_wr;
  wfr_pkg::ctrl_cmd_t          cmd;
  wfr_pkg::dp_stat_t           stat;
  logic                        in_ready;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    timeout_nxt = timeout_r;
    if (cfg_wr && cfg_paddr[2] == wfr_pkg::REG_TIMEOUT) begin
      timeout_nxt = cfg_pwdata[wfr_pkg::TIMER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= wfr_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == wfr_pkg::REG_TIMEOUT)
                      ? {{(wfr_pkg::CFG_DATA_W-wfr_pkg::TIMER_W){1'b0}}, timeout_r}
                      : '0;

  // controller
  wfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  // datapath
  wfr_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .max_bytes      (in_ch.max_bytes),
    .timeout        (timeout_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_bit_count  (out_ch.bit_count),
    .out_data_byte  (out_ch.data_byte),
    .out_byte_valid (out_ch.byte_valid),
    .out_last       (out_ch.last)
  );

endmodule

### tb/wiegand_frame_receiver_core_test.sv
// self-checking testbench of wiegand_frame_receiver_core: a scoreboard class with its
// own frame model checks every result transfer; tasks drive the channels and the config port
// depends on wfr_pkg, wfr_in_if, wfr_out_if and the rtl of the block
`timescale 1ns / 1ps

module wiegand_frame_receiver_core_test;

  localparam int OPCODE_W      = wfr_pkg::OPCODE_W;
  localparam int MAXB_W        = wfr_pkg::MAXB_W;
  localparam int BIT_COUNT_W   = wfr_pkg::BIT_COUNT_W;
  localparam int BYTE_W        = wfr_pkg::BYTE_W;
  localparam int TIMER_W       = wfr_pkg::TIMER_W;
  localparam int CFG_DATA_W    = wfr_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W    = wfr_pkg::CFG_ADDR_W;
  localparam int STORE_BYTES   = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int SHOW_LIMIT    = 10;
  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = {wfr_pkg::REG_TIMEOUT, 2'b00};

  typedef struct packed {
    logic [BIT_COUNT_W-1:0] bit_count;
    logic [BYTE_W-1:0]      data_byte;
    logic                   byte_valid;
    logic                   last;
  } frame_result_t;

  // frame model plus the queue of results it still waits for
  class frame_checker;
    logic [BYTE_W-1:0]  store_bytes [STORE_BYTES];
    int unsigned        bit_total;
    logic [TIMER_W-1:0] idle_count;
    logic [TIMER_W-1:0] timeout_ticks;
    frame_result_t      pending_results [$];
    int                 mismatches;
    int                 accepted;
    int                 produced;
    int                 checked;
    int                 reads;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      bit_total     = 0;
      idle_count    = wfr_pkg::TIMER_MAX;
      timeout_ticks = wfr_pkg::TIMEOUT_RESET;
      mismatches    = 0;
      accepted      = 0;
      produced      = 0;
      checked       = 0;
      reads         = 0;
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) $display("tb: mismatch at %0t: %s", $realtime, msg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void push_result(int unsigned bits, logic [BYTE_W-1:0] byte_val, logic vld,
                              logic lst);
      frame_result_t r;
      r.bit_count  = bits[BIT_COUNT_W-1:0];
      r.data_byte  = byte_val;
      r.byte_valid = vld;
      r.last       = lst;
      pending_results.push_back(r);
      produced++;
    endfunction

    // one accepted input transfer: update the model, queue what a read returns
    function void take_item(wfr_pkg::opcode_t op, logic [MAXB_W-1:0] maxb);
      int unsigned slot;
      int unsigned n;
      accepted++;
      case (op)
        wfr_pkg::OP_TICK: begin
          if (idle_count != wfr_pkg::TIMER_MAX) idle_count++;
        end
        wfr_pkg::OP_DATA0, wfr_pkg::OP_DATA1: begin
          slot = bit_total >> 3;
          if (slot < STORE_BYTES) begin
            store_bytes[slot] = {store_bytes[slot][BYTE_W-2:0], op == wfr_pkg::OP_DATA1};
            bit_total++;
          end
          idle_count = '0;
        end
        default: begin
          reads++;
          if (idle_count < timeout_ticks || bit_total == 0) begin
            push_result(0, '0, 1'b0, 1'b1);
          end else begin
            n = (bit_total + 7) >> 3;
            if (n > maxb) n = maxb;
            if (n > STORE_BYTES) n = STORE_BYTES;
            if (n > wfr_pkg::RESULT_CAP) n = wfr_pkg::RESULT_CAP;
            if (n == 0) begin
              push_result(bit_total, '0, 1'b0, 1'b1);
            end else begin
              for (int i = 0; i < n; i++)
                push_result(bit_total, store_bytes[i], 1'b1, i + 1 == n);
            end
            foreach (store_bytes[i]) store_bytes[i] = '0;
            bit_total = 0;
          end
        end
      endcase
    endfunction

    // one accepted result transfer against the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result bits=%0d byte=%02h valid=%0b last=%0b",
                               got.bit_count, got.data_byte, got.byte_valid, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.bit_count !== want.bit_count || got.data_byte !== want.data_byte ||
          got.byte_valid !== want.byte_valid || got.last !== want.last)
        note_failure($sformatf({"expected bits=%0d byte=%02h valid=%0b last=%0b, ",
                                "got bits=%0d byte=%02h valid=%0b last=%0b"},
                               want.bit_count, want.data_byte, want.byte_valid, want.last,
                               got.bit_count, got.data_byte, got.byte_valid, got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  wfr_in_if  in_ch ();
  wfr_out_if out_ch ();

  frame_checker sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cur_timeout = wfr_pkg::TIMEOUT_RESET;

  wiegand_frame_receiver_core #(
    .MAX_BYTES(STORE_BYTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // result sink: check each transfer, then pick ready for the next cycle
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.bit_count, out_ch.data_byte, out_ch.byte_valid, out_ch.last});
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // random max_bytes in a range
  function automatic logic [MAXB_W-1:0] rand_maxb(input int unsigned lo, input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[MAXB_W-1:0];
  endfunction

  // random opcode
  function automatic wfr_pkg::opcode_t rand_op();
    int unsigned v;
    v = $urandom_range(3);
    return wfr_pkg::opcode_t'(v[OPCODE_W-1:0]);
  endfunction

  // offer one item, with random idle cycles first, until the transfer happens
  task automatic send_item(input wfr_pkg::opcode_t op, input logic [MAXB_W-1:0] maxb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.max_bytes <= maxb;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_item(op, maxb);
  endtask

  // random data pulses followed by idle ticks
  task automatic send_frame(input int nbits, input int nticks);
    repeat (nbits)
      send_item($urandom_range(1) ? wfr_pkg::OP_DATA1 : wfr_pkg::OP_DATA0, rand_maxb(0, 127));
    repeat (nticks) send_item(wfr_pkg::OP_TICK, rand_maxb(0, 127));
  endtask

  // stop offering and let every expected result arrive
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb transfer: setup cycle, access until pready, then return to idle
  task automatic apb_transfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= TIMEOUT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write the timeout while idle and read it back
  task automatic set_timeout(input int value);
    logic [CFG_DATA_W-1:0] rd;
    wait_drained();
    apb_transfer(1'b1, value, rd);
    sb.timeout_ticks = value[TIMER_W-1:0];
    cur_timeout = value;
    apb_transfer(1'b0, '0, rd);
    if (rd[TIMER_W-1:0] !== value[TIMER_W-1:0])
      sb.note_failure($sformatf("timeout readback %0d, wrote %0d", rd[TIMER_W-1:0], value));
  endtask

  // random traffic: mostly whole frames, some noise and early reads
  task automatic run_random(input int item_goal, input int result_goal);
    int item_base;
    int result_base;
    int kind;
    int len;
    logic [MAXB_W-1:0] maxb;
    item_base   = sb.accepted;
    result_base = sb.produced;
    while (sb.accepted - item_base < item_goal || sb.produced - result_base < result_goal) begin
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0:       maxb = 7'd127;
        1:       maxb = 7'd0;
        2:       maxb = rand_maxb(1, 8);
        default: maxb = rand_maxb(0, 127);
      endcase
      if (kind < 75) begin
        len = $urandom_range(1, 12);
        send_frame(len, $urandom_range(cur_timeout, cur_timeout + 1));
        send_item(wfr_pkg::OP_READ, maxb);
      end else if (kind < 90) begin
        repeat (3) send_item(rand_op(), rand_maxb(0, 127));
      end else begin
        // read too early, then let the frame finish
        send_frame($urandom_range(1, 8), 0);
        send_item(wfr_pkg::OP_READ, rand_maxb(0, 127));
        send_frame(0, cur_timeout);
        send_item(wfr_pkg::OP_READ, maxb);
      end
    end
  endtask

  // main sequence
  initial begin
    logic [CFG_DATA_W-1:0] rd;
    logic [8:0] pattern;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= wfr_pkg::OP_TICK;
    in_ch.max_bytes <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the timeout register
    apb_transfer(1'b0, '0, rd);
    if (rd[TIMER_W-1:0] !== wfr_pkg::TIMEOUT_RESET)
      sb.note_failure($sformatf("timeout reset value %0d", rd[TIMER_W-1:0]));

    // directed: empty store with saturated timer, read before timeout
    send_item(wfr_pkg::OP_READ, 7'd127);
    send_item(wfr_pkg::OP_TICK, 7'd0);
    send_item(wfr_pkg::OP_DATA1, 7'd127);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // short frame completes after one tick
    set_timeout(1);
    send_item(wfr_pkg::OP_DATA0, 7'd0);
    send_item(wfr_pkg::OP_DATA1, 7'd0);
    send_item(wfr_pkg::OP_TICK, 7'd0);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // nine bits, read limited to one byte
    pattern = 9'b101001011;
    for (int i = 8; i >= 0; i--)
      send_item(pattern[i] ? wfr_pkg::OP_DATA1 : wfr_pkg::OP_DATA0, 7'd0);
    send_item(wfr_pkg::OP_TICK, 7'd127);
    send_item(wfr_pkg::OP_READ, 7'd1);

    // zero max_bytes still clears the store
    send_item(wfr_pkg::OP_DATA0, 7'd127);
    send_item(wfr_pkg::OP_TICK, 7'd0);
    send_item(wfr_pkg::OP_READ, 7'd0);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // zero timeout: complete at once
    set_timeout(0);
    send_item(wfr_pkg::OP_DATA1, 7'd0);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // store full: extra pulses drop their bits
    set_timeout(1);
    send_frame(STORE_BYTES * 8 + $urandom_range(1, 4), 1);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // largest timeout not reached, then a smaller one that the held frame meets
    set_timeout(65535);
    send_item(wfr_pkg::OP_DATA1, 7'd0);
    send_item(wfr_pkg::OP_DATA1, 7'd0);
    send_frame(0, 3);
    send_item(wfr_pkg::OP_READ, 7'd127);
    set_timeout(3);
    send_item(wfr_pkg::OP_READ, 7'd127);
    send_item(wfr_pkg::OP_READ, 7'd127);

    // random phase with no idling
    set_timeout($urandom_range(1, 3));
    run_random(8, 2);

    // sender idles
    send_idle_pct = 62;
    set_timeout(1);
    run_random(8, 2);

    // receiver stalls, with a long hold-off so the block backs up
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    set_timeout($urandom_range(1, 3));
    hold_left = 400;
    run_random(8, 2);

    // both sides idle
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    set_timeout(2);
    run_random(8, 2);

    wait_drained();
    $display("tb: %0d input transfers, %0d reads, %0d result transfers checked",
             sb.accepted, sb.reads, sb.checked);
    $display("tb: timeouts 0 to 65535, store overflow, four idle/stall mixes, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
